// ===== rtl/core/eps_pkg.sv =====
//------------------------------------------------------------------------------
// eps_pkg
// Shared types, constants and helpers of the edge preserving smoother.
//------------------------------------------------------------------------------
package eps_pkg;

   localparam int DEFAULT_MAX_WIDTH = 1024;
   localparam int WIDTH_BITS        = 11;
   localparam int HEIGHT_BITS       = 16;
   localparam int CSR_DATA_BITS     = 16;
   localparam int CSR_INDEX_BITS    = 1;
   localparam logic [HEIGHT_BITS-1:0] HEIGHT_CAP = 16'd65533;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_IMAGE_WIDTH  = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_IMAGE_HEIGHT = 1'b1;

   localparam int NUM_REGIONS = 9;
   localparam int SUM_BITS    = 12;  // 9 * 255
   localparam int SQ_BITS     = 20;  // 9 * 255^2
   localparam int VAR_BITS    = 24;  // n*Q - S^2 stays below 2^24

   typedef struct packed {
      logic [7:0] pixel_in;
      logic       frame_start;
   } req_word_type;

   typedef struct packed {
      logic [7:0] pixel_out;
      logic       frame_last;
   } rsp_word_type;

   // classified job handed from front to back
   typedef struct packed {
      logic [4:0][4:0][7:0] win;
      logic                 border;
      logic                 frame_last;
   } job_type;

   // region membership: bit (y*5+x) set when window cell belongs to region k
   function automatic logic [24:0] region_mask(input int k);
      logic [24:0] m;
      m = '0;
      case (k)
         0: m = 25'h0000000 | (25'b1 << 12) | (25'b111 << 1) | (25'b111 << 6);
         1: m = (25'b1 << 12) | (25'b11 << 3) | (25'b11 << 8) | (25'b1 << 13)
              | (25'b1 << 7);
         2: m = (25'b1 << 12) | (25'b11 << 8) | (25'b11 << 13) | (25'b11 << 18);
         3: m = (25'b1 << 12) | (25'b1 << 13) | (25'b111 << 17) | (25'b11 << 23);
         4: m = (25'b1 << 12) | (25'b111 << 16) | (25'b111 << 21);
         5: m = (25'b1 << 12) | (25'b1 << 11) | (25'b111 << 15) | (25'b11 << 20);
         6: m = (25'b1 << 12) | (25'b11 << 5) | (25'b11 << 10) | (25'b11 << 15);
         7: m = (25'b1 << 12) | (25'b11 << 0) | (25'b11 << 5) | (25'b1 << 11)
              | (25'b1 << 7);
         default: m = (25'b111 << 6) | (25'b111 << 11) | (25'b111 << 16);
      endcase
      return m;
   endfunction

endpackage

// ===== rtl/core/eps_front.sv =====
//------------------------------------------------------------------------------
// eps_front
// Counts raster position, keeps the line stores and window, classifies pixels.
//------------------------------------------------------------------------------
module eps_front #(
   parameter int MAX_WIDTH = eps_pkg::DEFAULT_MAX_WIDTH
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [eps_pkg::WIDTH_BITS-1:0]      width_eff,
   input  logic [eps_pkg::HEIGHT_BITS-1:0]     height_eff,
   input  logic                                in_valid,
   output logic                                in_ready,
   input  eps_pkg::req_word_type               in_word,
   output logic                                job_valid,
   input  logic                                job_ready,
   output eps_pkg::job_type                    job
);
   import eps_pkg::*;

   localparam int ROW_LEN = MAX_WIDTH + 2;
   localparam int CB      = $clog2(ROW_LEN + 1);
   localparam int AB      = $clog2(ROW_LEN);

   // stage A: read line stores; stage B: shift window and emit
   logic [31:0] mem [ROW_LEN];    // four 8-bit rows packed per column

   logic [HEIGHT_BITS-1:0] row_ff, row_in;
   logic [CB-1:0]          col_ff, col_in;
   logic                   a_valid_ff;
   logic [7:0]             a_pix_ff;
   logic [HEIGHT_BITS-1:0] a_row_ff;
   logic [CB-1:0]          a_col_ff;
   logic [31:0]            a_rd_ff;
   logic                   a_fwd_ff;
   logic [31:0]            a_fwd_word_ff;
   logic [31:0]            a_word;
   logic [4:0][4:0][7:0]   win_ff;
   logic                   b_valid_ff;
   logic                   b_border_ff, b_last_ff;

   logic [HEIGHT_BITS-1:0] r_cur;
   logic [CB-1:0]          c_cur;
   logic [CB-1:0]          w_c;
   logic                   adv, take;

   assign w_c = CB'(width_eff);
   assign adv = !b_valid_ff || job_ready;
   assign in_ready = adv;
   assign take = in_valid && in_ready;

   always_comb begin
      r_cur = row_ff;
      c_cur = col_ff;
      if (in_word.frame_start) begin
         r_cur = '0;
         c_cur = '0;
      end
      if (c_cur > w_c + CB'(1)) begin
         c_cur = '0;
         r_cur = r_cur + 1'b1;
      end
      if (r_cur > height_eff + 16'd1) r_cur = '0;
      row_in = r_cur;
      col_in = c_cur + 1'b1;
      if (col_in >= w_c + CB'(2)) begin
         col_in = '0;
         row_in = r_cur + 1'b1;
         if (row_in >= height_eff + 16'd2) row_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff     <= '0;
         col_ff     <= '0;
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         if (take) begin
            row_ff <= row_in;
            col_ff <= col_in;
         end
         if (adv) begin
            a_valid_ff <= take;
            b_valid_ff <= a_valid_ff && (a_row_ff >= 16'd2) && (a_col_ff >= CB'(2));
         end
      end
   end

   // line store: read in stage A; a frame restart can hit the column that is
   // being written back on the same edge, so that word is forwarded
   always_ff @(posedge clock) begin
      if (take) begin
         a_rd_ff       <= mem[c_cur[AB-1:0]];
         a_fwd_ff      <= a_valid_ff && (a_col_ff == c_cur);
         a_fwd_word_ff <= {a_pix_ff, a_word[31:8]};
         a_pix_ff      <= in_word.pixel_in;
         a_row_ff      <= r_cur;
         a_col_ff      <= c_cur;
      end
   end

   assign a_word = a_fwd_ff ? a_fwd_word_ff : a_rd_ff;

   // write back shifted column from the stage A registers
   always_ff @(posedge clock) begin
      if (adv && a_valid_ff)
         mem[a_col_ff[AB-1:0]] <= {a_pix_ff, a_word[31:8]};
   end

   logic [HEIGHT_BITS-1:0] cy;
   logic [CB-1:0]          cx;
   assign cy = a_row_ff - 16'd2;
   assign cx = a_col_ff - CB'(2);

   always_ff @(posedge clock) begin
      if (adv && a_valid_ff) begin
         for (int y = 0; y < 5; y++)
            for (int x = 0; x < 4; x++)
               win_ff[y][x] <= win_ff[y][x+1];
         for (int y = 0; y < 4; y++)
            win_ff[y][4] <= a_word[8*y +: 8];
         win_ff[4][4] <= a_pix_ff;
         b_border_ff <= (cy < 16'd2) || (cx < CB'(2)) ||
                        (cy + 16'd2 >= height_eff) || (cx + CB'(2) >= w_c);
         b_last_ff   <= (a_row_ff == height_eff + 16'd1) &&
                        (a_col_ff == w_c + CB'(1));
      end
   end

   assign job_valid      = b_valid_ff;
   assign job.win        = win_ff;
   assign job.border     = b_border_ff;
   assign job.frame_last = b_last_ff;

`ifndef ASSERT_OFF
   a_col_range: assert property (@(posedge clock) disable iff (reset)
      col_ff <= CB'(ROW_LEN - 1))
      else $error("column count out of range");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      b_valid_ff && !job_ready |=> b_valid_ff)
      else $error("job dropped while stalled");
   a_no_take_stall: assert property (@(posedge clock) disable iff (reset)
      b_valid_ff && !job_ready |-> !in_ready)
      else $error("input taken while stalled");
`endif

endmodule

// ===== rtl/core/eps_queue.sv =====
//------------------------------------------------------------------------------
// eps_queue
// Two-entry job queue between the front and the back.
//------------------------------------------------------------------------------
module eps_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  eps_pkg::job_type in_job,
   output logic             out_valid,
   input  logic             out_ready,
   output eps_pkg::job_type out_job
);
   import eps_pkg::*;

   job_type    slot_ff [2];
   logic       wp_ff, rp_ff;
   logic [1:0] cnt_ff;
   logic       push, pop;

   assign in_ready  = cnt_ff != 2'd2;
   assign out_valid = cnt_ff != 2'd0;
   assign out_job   = slot_ff[rp_ff];
   assign push = in_valid && in_ready;
   assign pop  = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= '0;
      end else begin
         if (push) wp_ff <= !wp_ff;
         if (pop)  rp_ff <= !rp_ff;
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wp_ff] <= in_job;
   end

`ifndef ASSERT_OFF
   a_cnt: assert property (@(posedge clock) disable iff (reset) cnt_ff <= 2'd2)
      else $error("queue count overflow");
   a_ptr: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd1) |-> (wp_ff != rp_ff))
      else $error("queue pointers inconsistent");
   a_push: assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> cnt_ff == $past(cnt_ff) + 2'd1)
      else $error("queue count missed push");
`endif

endmodule

// ===== rtl/core/eps_back.sv =====
//------------------------------------------------------------------------------
// eps_back
// Region statistics, least variance pick, mean; pipelined, registered output.
//------------------------------------------------------------------------------
module eps_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  job_valid,
   output logic                  job_ready,
   input  eps_pkg::job_type      job,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output eps_pkg::rsp_word_type rsp_word
);
   import eps_pkg::*;

   // stage 1: squares; stage 2: sums; stage 3: variances;
   // stage 4: compare tree; stage 5: mean
   logic        s1_v_ff, s2_v_ff, s3_v_ff, s4_v_ff, s5_v_ff;
   logic        s1_b_ff, s2_b_ff, s3_b_ff, s4_b_ff;
   logic        s1_l_ff, s2_l_ff, s3_l_ff, s4_l_ff, s5_l_ff;
   logic [7:0]  s1_c_ff, s2_c_ff, s3_c_ff, s4_c_ff;
   logic [7:0]  s1_p_ff [25];
   logic [15:0] s1_q_ff [25];
   logic [SUM_BITS-1:0] s2_s_ff [NUM_REGIONS];
   logic [SQ_BITS-1:0]  s2_q_ff [NUM_REGIONS];
   logic [SUM_BITS-1:0] s3_s_ff [NUM_REGIONS];
   logic [VAR_BITS+6:0] s3_key_ff [NUM_REGIONS];  // variance times 49*81
   logic [SUM_BITS-1:0] s4_s_ff;
   logic                s4_nine_ff;
   logic [7:0]  s5_pix_ff;
   logic [7:0]  out_pix_ff;
   logic        out_last_ff, out_v_ff;

   // every stage moves together; the output register gates the pipe
   logic move;
   assign move = !(out_v_ff && !rsp_ready);
   assign job_ready = move;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0; s2_v_ff <= 1'b0; s3_v_ff <= 1'b0;
         s4_v_ff <= 1'b0; s5_v_ff <= 1'b0; out_v_ff <= 1'b0;
      end else if (move) begin
         s1_v_ff <= job_valid;
         s2_v_ff <= s1_v_ff;
         s3_v_ff <= s2_v_ff;
         s4_v_ff <= s3_v_ff;
         s5_v_ff <= s4_v_ff;
         out_v_ff <= s5_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (move) begin
         s1_b_ff <= job.border; s1_l_ff <= job.frame_last; s1_c_ff <= job.win[2][2];
         for (int i = 0; i < 25; i++) begin
            s1_p_ff[i] <= job.win[i/5][i%5];
            s1_q_ff[i] <= 16'(job.win[i/5][i%5]) * 16'(job.win[i/5][i%5]);
         end
         s2_b_ff <= s1_b_ff; s2_l_ff <= s1_l_ff; s2_c_ff <= s1_c_ff;
         for (int k = 0; k < NUM_REGIONS; k++) begin
            logic [24:0]         m;
            logic [SUM_BITS-1:0] s;
            logic [SQ_BITS-1:0]  q;
            m = region_mask(k);
            s = '0;
            q = '0;
            for (int i = 0; i < 25; i++)
               if (m[i]) begin
                  s = s + SUM_BITS'(s1_p_ff[i]);
                  q = q + SQ_BITS'(s1_q_ff[i]);
               end
            s2_s_ff[k] <= s;
            s2_q_ff[k] <= q;
         end
         // key = (nQ-S^2) * (other n)^2 so keys share denominator 49*81
         s3_b_ff <= s2_b_ff; s3_l_ff <= s2_l_ff; s3_c_ff <= s2_c_ff;
         for (int k = 0; k < NUM_REGIONS; k++) begin
            logic [VAR_BITS-1:0] v;
            if (k < 8) begin
               v = VAR_BITS'(24'(s2_q_ff[k]) * 24'd7) -
                   VAR_BITS'(24'(s2_s_ff[k]) * 24'(s2_s_ff[k]));
               s3_key_ff[k] <= (VAR_BITS+7)'(v) * 31'd81;
            end else begin
               v = VAR_BITS'(24'(s2_q_ff[k]) * 24'd9) -
                   VAR_BITS'(24'(s2_s_ff[k]) * 24'(s2_s_ff[k]));
               s3_key_ff[k] <= (VAR_BITS+7)'(v) * 31'd49;
            end
            s3_s_ff[k] <= s2_s_ff[k];
         end
         s4_b_ff <= s3_b_ff; s4_l_ff <= s3_l_ff; s4_c_ff <= s3_c_ff;
         begin
            logic [VAR_BITS+6:0] tk [NUM_REGIONS];
            logic [3:0]          ti [NUM_REGIONS];
            for (int k = 0; k < NUM_REGIONS; k++) begin
               tk[k] = s3_key_ff[k];
               ti[k] = 4'(k);
            end
            // pairwise tree; the left side holds lower indices and wins ties
            for (int span = 1; span < NUM_REGIONS; span = span * 2)
               for (int k = 0; k + span < NUM_REGIONS; k = k + 2 * span)
                  if (tk[k + span] < tk[k]) begin
                     tk[k] = tk[k + span];
                     ti[k] = ti[k + span];
                  end
            s4_s_ff    <= s3_s_ff[ti[0]];
            s4_nine_ff <= (ti[0] == 4'd8);
         end
         s5_l_ff <= s4_l_ff;
         if (s4_b_ff)
            s5_pix_ff <= s4_c_ff;
         else if (s4_nine_ff)
            s5_pix_ff <= 8'((24'(s4_s_ff) * 24'd3641) >> 15);   // /9
         else
            s5_pix_ff <= 8'((24'(s4_s_ff) * 24'd4682) >> 15);   // /7
         out_pix_ff  <= s5_pix_ff;
         out_last_ff <= s5_l_ff;
      end
   end

   assign rsp_valid           = out_v_ff;
   assign rsp_word.pixel_out  = out_pix_ff;
   assign rsp_word.frame_last = out_last_ff;

`ifndef ASSERT_OFF
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      out_v_ff && !rsp_ready |=> out_v_ff && $stable(out_pix_ff))
      else $error("result changed while stalled");
   a_no_accept: assert property (@(posedge clock) disable iff (reset)
      out_v_ff && !rsp_ready |-> !job_ready)
      else $error("job taken during stall");
   a_flow: assert property (@(posedge clock) disable iff (reset)
      move && s5_v_ff |=> out_v_ff)
      else $error("result lost");
`endif

endmodule

// ===== rtl/core/edge_preserving_smoother.sv =====
//------------------------------------------------------------------------------
// edge_preserving_smoother
// 5x5 least-variance region smoother on a raster pixel stream.
//------------------------------------------------------------------------------
// Usage: pixels enter on req_ (valid/ready) in raster order, each row followed
// by two padding words and each frame by two padding rows; req frame_start
// restarts the raster counters. Results leave on rsp_ (valid/ready), one per
// real pixel, frame_last on the final pixel. csr_ writes set image_width
// (index 0) and image_height (index 1); the user must make them only while
// the block is idle, which the block itself does not enforce.
// Throughput: one word per cycle while req_ready is high; the front reads and
// writes the packed line store once per word. The word that completes a window
// passes two front stages, the queue and six back stages before rsp_valid.
// Reset clears counters and handshakes; line stores keep stale data.
// When rsp_ready is low the back pipeline stalls, the queue fills, and then
// req_ready drops.
//------------------------------------------------------------------------------
module edge_preserving_smoother #(
   parameter int MAX_WIDTH = eps_pkg::DEFAULT_MAX_WIDTH
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  eps_pkg::req_word_type               req_word,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output eps_pkg::rsp_word_type               rsp_word,
   input  logic                                csr_write,
   input  logic [eps_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [eps_pkg::CSR_DATA_BITS-1:0]   csr_data
);
   import eps_pkg::*;

   logic [WIDTH_BITS-1:0]  width_ff;
   logic [HEIGHT_BITS-1:0] height_ff;
   logic [WIDTH_BITS-1:0]  width_eff;
   logic [HEIGHT_BITS-1:0] height_eff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_BITS'(256);
         height_ff <= HEIGHT_BITS'(256);
      end else if (csr_write) begin
         case (csr_index)
            CSR_IMAGE_WIDTH:  width_ff  <= csr_data[WIDTH_BITS-1:0];
            CSR_IMAGE_HEIGHT: height_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      width_eff = width_ff;
      if (width_ff == '0) width_eff = WIDTH_BITS'(1);
      if (32'(width_ff) > MAX_WIDTH) width_eff = WIDTH_BITS'(MAX_WIDTH);
      height_eff = height_ff;
      if (height_ff == '0) height_eff = HEIGHT_BITS'(1);
      if (height_ff > HEIGHT_CAP) height_eff = HEIGHT_CAP;
   end

   logic    f_valid, f_ready, q_valid, q_ready;
   job_type f_job, q_job;

   eps_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
      .clock, .reset, .width_eff, .height_eff,
      .in_valid(req_valid), .in_ready(req_ready), .in_word(req_word),
      .job_valid(f_valid), .job_ready(f_ready), .job(f_job));

   eps_queue u_queue (
      .clock, .reset,
      .in_valid(f_valid), .in_ready(f_ready), .in_job(f_job),
      .out_valid(q_valid), .out_ready(q_ready), .out_job(q_job));

   eps_back u_back (
      .clock, .reset,
      .job_valid(q_valid), .job_ready(q_ready), .job(q_job),
      .rsp_valid, .rsp_ready, .rsp_word);

endmodule

// ===== bench/edge_preserving_smoother_tb.sv =====
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// edge_preserving_smoother_tb
// Self-checking bench: raster frames of random size and content go in on req_,
// every rsp_ word is compared with an in-bench 5x5 least-variance predictor.
//------------------------------------------------------------------------------
module edge_preserving_smoother_tb;
   import eps_pkg::*;

   localparam int MAXW    = DEFAULT_MAX_WIDTH;
   localparam int ROW_LEN = MAXW + 2;
   localparam int DRAIN   = 40;

   typedef enum int {STYLE_RANDOM, STYLE_FLAT, STYLE_FEW, STYLE_STEP} pixel_style_type;

   typedef struct packed {
      logic [7:0] pix;
      logic       fs;
      logic       typed;
      logic [7:0] want_pix;
      logic       want_last;
   } dir_row_type;

   // wedge offsets (dy, dx), center first
   localparam int WDY [8][7] = '{
      '{0,-2,-2,-2,-1,-1,-1}, '{0,-2,-2,-1,-1,-1, 0}, '{0,-1,-1, 0, 0, 1, 1},
      '{0, 0, 1, 1, 1, 2, 2}, '{0, 1, 1, 1, 2, 2, 2}, '{0, 0, 1, 1, 1, 2, 2},
      '{0,-1,-1, 0, 0, 1, 1}, '{0,-2,-2,-1,-1,-1, 0}};
   localparam int WDX [8][7] = '{
      '{0,-1, 0, 1,-1, 0, 1}, '{0, 1, 2, 0, 1, 2, 1}, '{0, 1, 2, 1, 2, 1, 2},
      '{0, 1, 0, 1, 2, 1, 2}, '{0,-1, 0, 1,-1, 0, 1}, '{0,-1,-2,-1, 0,-2,-1},
      '{0,-2,-1,-2,-1,-2,-1}, '{0,-2,-1,-2,-1, 0,-1}};

   // three 1x1 frames: the only result of each is the pixel itself, last set
   localparam dir_row_type DIR_TABLE [27] = '{
      '{8'hFF,1,0,0,0}, '{8'h00,0,0,0,0}, '{8'hAA,0,0,0,0},
      '{8'h55,0,0,0,0}, '{8'hFF,0,0,0,0}, '{8'h00,0,0,0,0},
      '{8'h0F,0,0,0,0}, '{8'hF0,0,0,0,0}, '{8'h81,0,1,8'hFF,1},
      '{8'h00,1,0,0,0}, '{8'hFF,0,0,0,0}, '{8'h55,0,0,0,0},
      '{8'hAA,0,0,0,0}, '{8'hFF,0,0,0,0}, '{8'hFF,0,0,0,0},
      '{8'h7E,0,0,0,0}, '{8'h01,0,0,0,0}, '{8'hFF,0,1,8'h00,1},
      // next frame follows without frame_start: counters wrap
      '{8'h5A,0,0,0,0}, '{8'hC3,0,0,0,0}, '{8'h3C,0,0,0,0},
      '{8'h00,0,0,0,0}, '{8'hFF,0,0,0,0}, '{8'h80,0,0,0,0},
      '{8'h7F,0,0,0,0}, '{8'h11,0,0,0,0}, '{8'hEE,0,1,8'h5A,1}};

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   req_word_type              req_word = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   rsp_word_type              rsp_word;
   logic                      csr_write = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_data = '0;

   edge_preserving_smoother dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor state
   logic [7:0]  lines [4][ROW_LEN];
   logic [7:0]  win [5][5];
   int unsigned row_pos, col_pos;
   logic [10:0] width_reg;
   logic [15:0] height_reg;

   rsp_word_type expected_px [$];
   int sender_idle, receiver_idle;
   int errors, words_sent, results_seen, frames_sent;

   task automatic report(input string what, input int got, input int want);
      $display("%0t mismatch %s: got %0h want %0h", $time, what, got, want);
      errors++;
   endtask

   function automatic logic [7:0] smooth_window();
      longint s, q, n, num, den, best_num, best_den, best_s, best_n, v;
      best_num = 0; best_den = 1; best_s = 0; best_n = 1;
      for (int k = 0; k < 9; k++) begin
         s = 0; q = 0;
         if (k < 8) begin
            n = 7;
            for (int i = 0; i < 7; i++) begin
               v = win[2 + WDY[k][i]][2 + WDX[k][i]];
               s += v; q += v * v;
            end
         end else begin
            n = 9;
            for (int i = 1; i < 4; i++)
               for (int j = 1; j < 4; j++) begin
                  v = win[i][j];
                  s += v; q += v * v;
               end
         end
         num = n * q - s * s;
         den = n * n;
         // strict compare: ties keep lower region
         if (k == 0 || num * best_den < best_num * den) begin
            best_num = num; best_den = den; best_s = s; best_n = n;
         end
      end
      return 8'(best_s / best_n);
   endfunction

   // advance the predictor by one accepted word; returns 1 when a result is due
   function automatic bit predict_word(input req_word_type w, output rsp_word_type res);
      int unsigned wd, ht, r, c, cy, cx;
      bit made;
      wd = width_reg; ht = height_reg;
      if (wd < 1) wd = 1;
      if (wd > MAXW) wd = MAXW;
      if (ht < 1) ht = 1;
      if (ht > HEIGHT_CAP) ht = HEIGHT_CAP;
      r = row_pos; c = col_pos;
      made = 0; res = '0;
      if (w.frame_start) begin r = 0; c = 0; end
      if (c > wd + 1) begin c = 0; r++; end
      if (r > ht + 1) r = 0;
      for (int y = 0; y < 5; y++)
         for (int x = 0; x < 4; x++) win[y][x] = win[y][x+1];
      for (int y = 0; y < 4; y++) win[y][4] = lines[y][c];
      win[4][4] = w.pixel_in;
      for (int y = 0; y < 3; y++) lines[y][c] = lines[y+1][c];
      lines[3][c] = w.pixel_in;
      if (r >= 2 && c >= 2) begin
         cy = r - 2; cx = c - 2;
         if (cy < 2 || cx < 2 || cy + 2 >= ht || cx + 2 >= wd) res.pixel_out = win[2][2];
         else res.pixel_out = smooth_window();
         res.frame_last = (r == ht + 1 && c == wd + 1);
         made = 1;
      end
      c++;
      if (c >= wd + 2) begin
         c = 0; r++;
         if (r >= ht + 2) r = 0;
      end
      row_pos = r; col_pos = c;
      return made;
   endfunction

   // drive one word; valid is only dropped during a sender idle cycle
   task automatic send_word(input logic [7:0] pix, input logic fs,
                            input bit typed, input rsp_word_type typed_res);
      rsp_word_type res;
      while ($urandom_range(99) < sender_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= '{pixel_in: pix, frame_start: fs};
      do @(posedge clock); while (!req_ready);
      if (predict_word('{pixel_in: pix, frame_start: fs}, res) || typed)
         expected_px.push_back(typed ? typed_res : res);
      words_sent++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (expected_px.size() != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
   endtask

   task automatic set_size(input int wd, input int ht);
      drain();
      csr_write <= 1'b1; csr_index <= CSR_IMAGE_WIDTH; csr_data <= CSR_DATA_BITS'(wd);
      @(posedge clock);
      width_reg = 11'(wd);
      csr_index <= CSR_IMAGE_HEIGHT; csr_data <= CSR_DATA_BITS'(ht);
      @(posedge clock);
      height_reg = 16'(ht);
      csr_write <= 1'b0;
   endtask

   function automatic logic [7:0] pick_pixel(input pixel_style_type st, input int x,
                                             input logic [7:0] base);
      case (st)
         STYLE_FLAT: return base;
         STYLE_FEW:  return base ^ 8'($urandom_range(1) << $urandom_range(7));
         STYLE_STEP: return (x % 7 < 3) ? base : ~base;
         default:    return 8'($urandom);
      endcase
   endfunction

   // one frame at effective size wd x ht; may be cut short to break the raster
   task automatic send_frame(input int wd, input int ht, input bit with_fs,
                             input bit cut);
      int total, stop_at, x;
      pixel_style_type st;
      logic [7:0] base;
      total = (wd + 2) * (ht + 2);
      stop_at = cut ? $urandom_range((total > 101) ? 100 : total - 1, 1) : total;
      st = pixel_style_type'($urandom_range(3));
      base = 8'($urandom);
      for (int i = 0; i < stop_at; i++) begin
         x = i % (wd + 2);
         send_word(pick_pixel(st, x, base), (i == 0) && with_fs, 0, '0);
      end
      frames_sent++;
   endtask

   always @(posedge clock)
      rsp_ready <= ($urandom_range(99) >= receiver_idle);

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen++;
         if (expected_px.size() == 0) begin
            report("unexpected word", rsp_word, 0);
         end else begin
            if (rsp_word.pixel_out !== expected_px[0].pixel_out)
               report("pixel_out", rsp_word.pixel_out, expected_px[0].pixel_out);
            if (rsp_word.frame_last !== expected_px[0].frame_last)
               report("frame_last", rsp_word.frame_last, expected_px[0].frame_last);
            void'(expected_px.pop_front());
         end
      end
   end

   initial begin
      #50ms;
      $display("*** FAILED ***");
      $finish;
   end

   initial begin
      int wd, ht, target;
      bit need_fs, cut;
      errors = 0; words_sent = 0; results_seen = 0; frames_sent = 0;
      sender_idle = 23; receiver_idle = 63;
      width_reg = 11'd256; height_reg = 16'd256;
      row_pos = 0; col_pos = 0;
      for (int y = 0; y < 5; y++) for (int x = 0; x < 5; x++) win[y][x] = '0;
      for (int y = 0; y < 4; y++) for (int x = 0; x < ROW_LEN; x++) lines[y][x] = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      set_size(1, 1);
      foreach (DIR_TABLE[i])
         send_word(DIR_TABLE[i].pix, DIR_TABLE[i].fs, DIR_TABLE[i].typed,
                   '{pixel_out: DIR_TABLE[i].want_pix, frame_last: DIR_TABLE[i].want_last});

      target = 27;
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin sender_idle = 23; receiver_idle = 63; end
            1: begin sender_idle = 63; receiver_idle = 23; end
            default: begin sender_idle = 0; receiver_idle = 0; end
         endcase
         // register extremes, two in phase 0 and one in each later phase; large sizes only as partial frames
         case (phase)
            0: begin set_size(0, 0); send_frame(1, 1, 1, 0);
                     set_size(1024, 2); send_frame(1024, 2, 1, 1); end
            1: begin set_size(2047, 1); send_frame(1024, 1, 1, 1); end
            default: begin set_size(1, 65535); send_frame(1, 65533, 1, 1); end
         endcase
         need_fs = 1;
         target = words_sent + 430;
         while (words_sent < target) begin
            wd = ($urandom_range(9) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 1);
            ht = $urandom_range(9, 1);
            set_size(wd, ht);
            cut = ($urandom_range(9) == 0);
            send_frame(wd, ht, need_fs || ($urandom_range(3) != 0), cut);
            need_fs = cut;
         end
      end

      drain();
      $display("sent %0d words in %0d frames, checked %0d results, %0d errors",
               words_sent, frames_sent, results_seen, errors);
      $display("full frames up to 40x9, clamped sizes in partial frames, three idle mixes");
      if (errors == 0 && expected_px.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/core/eps_pkg.sv
rtl/core/eps_front.sv
rtl/core/eps_queue.sv
rtl/core/eps_back.sv
rtl/core/edge_preserving_smoother.sv
bench/edge_preserving_smoother_tb.sv
